// ===== rtl/core/attitude_command_frame_builder_defines.svh =====
// assertion macros used by the checker file
`ifndef ATTITUDE_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define ATTITUDE_COMMAND_FRAME_BUILDER_DEFINES_SVH

// checked on every rising edge outside reset
`define ACFB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("acfb assertion failed");

// checked on every rising edge, reset included
`define ACFB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("acfb assertion failed");

`endif

// ===== rtl/core/acfb_pkg.sv =====
package acfb_pkg;

  localparam int ByteW    = 8;
  localparam int NumAxes  = 4;
  localparam int FrameLen = 11;
  localparam int RemW     = $clog2(FrameLen + 1);
  localparam int RegIdxW  = 3;

  localparam logic [ByteW-1:0] FrameStart = 8'hFA;
  localparam logic [ByteW-1:0] FrameStop  = 8'hFB;

  localparam logic signed [ByteW-1:0] LimitMaxReset = 8'sd127;
  localparam logic signed [ByteW-1:0] LimitMinReset = -8'sd128;

  typedef enum logic [RegIdxW-1:0] {
    RegRollMax   = 3'd0,
    RegRollMin   = 3'd1,
    RegPitchMax  = 3'd2,
    RegPitchMin  = 3'd3,
    RegYawMax    = 3'd4,
    RegYawMin    = 3'd5,
    RegThrustMax = 3'd6,
    RegThrustMin = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [ByteW-1:0] hi;
    logic signed [ByteW-1:0] lo;
  } limits_t;

endpackage

// ===== rtl/core/acfb_if.sv =====
interface acfb_cmd_if;
  logic                valid;
  logic                ready;
  logic signed [7:0]   roll_delta;
  logic        [7:0]   roll_time;
  logic signed [7:0]   pitch_delta;
  logic        [7:0]   pitch_time;
  logic signed [7:0]   yaw_delta;
  logic        [7:0]   yaw_time;
  logic signed [7:0]   thrust_delta;
  logic        [7:0]   thrust_time;

  modport source (
    output valid, roll_delta, roll_time, pitch_delta, pitch_time,
           yaw_delta, yaw_time, thrust_delta, thrust_time,
    input  ready
  );
  modport sink (
    input  valid, roll_delta, roll_time, pitch_delta, pitch_time,
           yaw_delta, yaw_time, thrust_delta, thrust_time,
    output ready
  );
endinterface

interface acfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface acfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/acfb_axis_clamp.sv =====
module acfb_axis_clamp (
  input  logic signed [acfb_pkg::ByteW-1:0] delta_i,
  input  acfb_pkg::limits_t                 lim_i,
  output logic signed [acfb_pkg::ByteW-1:0] clamped_o
);

  logic signed [acfb_pkg::ByteW-1:0] upper_cut;

  // max first, then min, so a crossed min wins
  assign upper_cut = (delta_i > lim_i.hi) ? lim_i.hi : delta_i;
  assign clamped_o = (upper_cut < lim_i.lo) ? lim_i.lo : upper_cut;

endmodule

// ===== rtl/core/attitude_command_frame_builder.sv =====
// Attitude command frame builder. Each accepted command (four signed deltas, each with a
// duration byte) is clamped per axis against the max/min limit registers, max first and
// min last, and turned into an 11-word frame: 0xFA, roll, roll time, pitch, pitch time,
// yaw, yaw time, thrust, thrust time, 8-bit wrapping sum of those eight bytes, 0xFB, with
// frame_end set on the 0xFB word. The single output word register drains the frame shift
// register at one word per cycle while the sink does not stall. The next command is taken
// in the same cycle its predecessor's last word moves to the output, so commands stream
// back to back when the sink never stalls. A command's first word passes from the frame
// shift register into the output word register before it is offered. Limit registers
// may be written at any time the block is idle; the config port is always ready and
// writes to its eight indexes take effect at once.
module attitude_command_frame_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  acfb_cfg_if.sink     cfg_i,
  acfb_cmd_if.sink     cmd_i,
  acfb_frame_if.source frame_o
);

  acfb_pkg::limits_t lim_q [acfb_pkg::NumAxes];

  logic signed [acfb_pkg::ByteW-1:0] delta   [acfb_pkg::NumAxes];
  logic        [acfb_pkg::ByteW-1:0] dur     [acfb_pkg::NumAxes];
  logic signed [acfb_pkg::ByteW-1:0] clamped [acfb_pkg::NumAxes];
  logic        [acfb_pkg::ByteW-1:0] new_frame [acfb_pkg::FrameLen];
  logic        [acfb_pkg::ByteW-1:0] csum;

  logic [acfb_pkg::ByteW-1:0] shift_q [acfb_pkg::FrameLen];
  logic [acfb_pkg::RemW-1:0]  rem_q;
  logic                       busy_q;
  logic                       out_valid_q;
  logic [acfb_pkg::ByteW-1:0] out_byte_q;
  logic                       out_end_q;

  logic out_load;
  logic last_load;
  logic in_acc;

  // limit registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < acfb_pkg::NumAxes; a++) begin
        lim_q[a].hi <= acfb_pkg::LimitMaxReset;
        lim_q[a].lo <= acfb_pkg::LimitMinReset;
      end
    end else if (cfg_i.valid) begin
      unique case (acfb_pkg::reg_idx_e'(cfg_i.index))
        acfb_pkg::RegRollMax:   lim_q[0].hi <= cfg_i.data;
        acfb_pkg::RegRollMin:   lim_q[0].lo <= cfg_i.data;
        acfb_pkg::RegPitchMax:  lim_q[1].hi <= cfg_i.data;
        acfb_pkg::RegPitchMin:  lim_q[1].lo <= cfg_i.data;
        acfb_pkg::RegYawMax:    lim_q[2].hi <= cfg_i.data;
        acfb_pkg::RegYawMin:    lim_q[2].lo <= cfg_i.data;
        acfb_pkg::RegThrustMax: lim_q[3].hi <= cfg_i.data;
        acfb_pkg::RegThrustMin: lim_q[3].lo <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // frame assembly
  assign delta[0] = cmd_i.roll_delta;
  assign delta[1] = cmd_i.pitch_delta;
  assign delta[2] = cmd_i.yaw_delta;
  assign delta[3] = cmd_i.thrust_delta;
  assign dur[0]   = cmd_i.roll_time;
  assign dur[1]   = cmd_i.pitch_time;
  assign dur[2]   = cmd_i.yaw_time;
  assign dur[3]   = cmd_i.thrust_time;

  for (genvar a = 0; a < acfb_pkg::NumAxes; a++) begin : g_axis
    acfb_axis_clamp u_clamp (
      .delta_i   (delta[a]),
      .lim_i     (lim_q[a]),
      .clamped_o (clamped[a])
    );
  end

  always_comb begin
    csum = '0;
    for (int a = 0; a < acfb_pkg::NumAxes; a++) begin
      csum = csum + acfb_pkg::ByteW'(clamped[a]) + dur[a];
    end
    new_frame[0] = acfb_pkg::FrameStart;
    for (int a = 0; a < acfb_pkg::NumAxes; a++) begin
      new_frame[2*a+1] = acfb_pkg::ByteW'(clamped[a]);
      new_frame[2*a+2] = dur[a];
    end
    new_frame[acfb_pkg::FrameLen-2] = csum;
    new_frame[acfb_pkg::FrameLen-1] = acfb_pkg::FrameStop;
  end

  // handshake: next command enters as the last word leaves the shifter
  assign out_load    = busy_q && (!out_valid_q || frame_o.ready);
  assign last_load   = out_load && (rem_q == acfb_pkg::RemW'(1));
  assign cmd_i.ready = !busy_q || last_load;
  assign in_acc      = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      rem_q  <= acfb_pkg::RemW'(acfb_pkg::FrameLen);
    end else if (out_load) begin
      rem_q <= rem_q - acfb_pkg::RemW'(1);
      if (last_load) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      shift_q <= new_frame;
    end else if (out_load) begin
      for (int k = 0; k < acfb_pkg::FrameLen - 1; k++) begin
        shift_q[k] <= shift_q[k+1];
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (frame_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= shift_q[0];
      out_end_q  <= (rem_q == acfb_pkg::RemW'(1));
    end
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.frame_end  = out_end_q;

endmodule

// ===== rtl/core/acfb_checker.sv =====
`include "attitude_command_frame_builder_defines.svh"

module acfb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [acfb_pkg::ByteW-1:0] out_byte_i,
  input logic                       out_end_i
);

  logic                       out_acc;
  logic                       at_sum;
  logic                       at_end;
  logic [acfb_pkg::RemW-1:0]  pos_q;
  logic [acfb_pkg::ByteW-1:0] sum_q;

  assign out_acc = out_valid_i && out_ready_i;
  assign at_sum  = (pos_q == acfb_pkg::RemW'(acfb_pkg::FrameLen - 2));
  assign at_end  = (pos_q == acfb_pkg::RemW'(acfb_pkg::FrameLen - 1));

  // word position within the frame and running sum of the command bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else if (out_acc) begin
      if (pos_q == acfb_pkg::RemW'(acfb_pkg::FrameLen - 1)) begin
        pos_q <= '0;
        sum_q <= '0;
      end else begin
        pos_q <= pos_q + acfb_pkg::RemW'(1);
        if (pos_q != '0 && pos_q < acfb_pkg::RemW'(acfb_pkg::FrameLen - 2)) begin
          sum_q <= sum_q + out_byte_i;
        end
      end
    end
  end

  `ACFB_ASSERT(a_start_word, clk_i, rst_ni, out_acc && pos_q == '0 |-> out_byte_i == acfb_pkg::FrameStart)
  `ACFB_ASSERT(a_end_mark, clk_i, rst_ni, out_acc |-> out_end_i == at_end)
  `ACFB_ASSERT(a_checksum, clk_i, rst_ni, out_acc && at_sum |-> out_byte_i == sum_q)
  `ACFB_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind attitude_command_frame_builder acfb_checker u_acfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .out_byte_i  (frame_o.frame_byte),
  .out_end_i   (frame_o.frame_end)
);

// ===== dv/attitude_command_frame_builder_test.sv =====
`timescale 1ns / 1ps

module attitude_command_frame_builder_test;

  localparam int CycleLimit = 1_000_000;

  typedef enum logic {
    RowCmd,
    RowCfg
  } row_kind_e;

  // cmd: {roll, roll_time, pitch, pitch_time, yaw, yaw_time, thrust, thrust_time}
  // want: {roll, pitch, yaw, thrust, checksum} after clamping
  typedef struct packed {
    row_kind_e          kind;
    acfb_pkg::reg_idx_e idx;
    logic [7:0]         data;
    logic [63:0]        cmd;
    logic               typed;
    logic [39:0]        want;
  } script_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic clk_i;
  logic rst_ni;

  acfb_cfg_if   cfg_bus ();
  acfb_cmd_if   cmd_bus ();
  acfb_frame_if frame_bus ();

  attitude_command_frame_builder u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .cmd_i   (cmd_bus),
    .frame_o (frame_bus)
  );

  logic signed [7:0] axis_max [acfb_pkg::NumAxes];
  logic signed [7:0] axis_min [acfb_pkg::NumAxes];
  frame_word_t       pending_words [$];
  script_row_t       script [$];
  frame_word_t       got_word;
  int                mismatches;
  int                cycle_cnt;
  int                stall_left;
  bit                no_idle;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  function automatic script_row_t cmd_row(logic [63:0] c, logic typed, logic [39:0] want);
    script_row_t row;
    row = '0;
    row.kind = RowCmd;
    row.cmd = c;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic script_row_t cfg_row(acfb_pkg::reg_idx_e idx, logic [7:0] data);
    script_row_t row;
    row = '0;
    row.kind = RowCfg;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int pick_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [7:0] clamp_delta(logic signed [7:0] d,
                                                    logic signed [7:0] hi,
                                                    logic signed [7:0] lo);
    logic signed [7:0] v;
    v = (d > hi) ? hi : d;
    v = (v < lo) ? lo : v;
    return v;
  endfunction

  function automatic void push_frame(logic [63:0] body, logic [7:0] sum);
    pending_words.push_back('{data: acfb_pkg::FrameStart, last: 1'b0});
    for (int k = 0; k < 8; k++) begin
      pending_words.push_back('{data: body[63-8*k -: 8], last: 1'b0});
    end
    pending_words.push_back('{data: sum, last: 1'b0});
    pending_words.push_back('{data: acfb_pkg::FrameStop, last: 1'b1});
  endfunction

  function automatic void predict_frame(logic [63:0] c);
    logic [63:0] body;
    logic [7:0]  sum;
    for (int a = 0; a < acfb_pkg::NumAxes; a++) begin
      body[63-16*a -: 8] = clamp_delta(c[63-16*a -: 8], axis_max[a], axis_min[a]);
      body[55-16*a -: 8] = c[55-16*a -: 8];
    end
    sum = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + body[63-8*k -: 8];
    end
    push_frame(body, sum);
  endfunction

  // values near the active limits hit the clamp boundaries often
  function automatic logic [7:0] pick_delta(int a);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0: v = -128;
        1: v = 127;
        2: v = 0;
        default: v = -1;
      endcase
    end else if (r < 5) begin
      if ($urandom_range(0, 1) == 1) v = axis_max[a];
      else v = axis_min[a];
      v = v + int'($urandom_range(0, 4)) - 2;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
    end else begin
      v = $urandom_range(0, 255);
    end
    return v[7:0];
  endfunction

  function automatic logic [63:0] random_cmd();
    logic [63:0] c;
    for (int a = 0; a < acfb_pkg::NumAxes; a++) begin
      c[63-16*a -: 8] = pick_delta(a);
      c[55-16*a -: 8] = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return 8'h80;
      1: return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %02h, got %02h (cycle %0d)", what, want, got,
               cycle_cnt);
    end
  endtask

  // limits only change once the frame in flight has drained
  task automatic write_limit(acfb_pkg::reg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      acfb_pkg::RegRollMax:   axis_max[0] = val;
      acfb_pkg::RegRollMin:   axis_min[0] = val;
      acfb_pkg::RegPitchMax:  axis_max[1] = val;
      acfb_pkg::RegPitchMin:  axis_min[1] = val;
      acfb_pkg::RegYawMax:    axis_max[2] = val;
      acfb_pkg::RegYawMin:    axis_min[2] = val;
      acfb_pkg::RegThrustMax: axis_max[3] = val;
      acfb_pkg::RegThrustMin: axis_min[3] = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_cmd(logic [63:0] c, logic typed, logic [39:0] want);
    int          gap;
    logic [63:0] body;
    gap = pick_idle();
    repeat (gap) begin
      @(negedge clk_i);
      cmd_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    cmd_bus.valid        = 1'b1;
    cmd_bus.roll_delta   = c[63:56];
    cmd_bus.roll_time    = c[55:48];
    cmd_bus.pitch_delta  = c[47:40];
    cmd_bus.pitch_time   = c[39:32];
    cmd_bus.yaw_delta    = c[31:24];
    cmd_bus.yaw_time     = c[23:16];
    cmd_bus.thrust_delta = c[15:8];
    cmd_bus.thrust_time  = c[7:0];
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (typed) begin
      for (int a = 0; a < acfb_pkg::NumAxes; a++) begin
        body[63-16*a -: 8] = want[39-8*a -: 8];
        body[55-16*a -: 8] = c[55-16*a -: 8];
      end
      push_frame(body, want[7:0]);
    end else begin
      predict_frame(c);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      frame_bus.ready = 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_idle();
      frame_bus.ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && frame_bus.valid && frame_bus.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 8'h00, frame_bus.frame_byte);
      end else begin
        got_word = pending_words.pop_front();
        if (frame_bus.frame_byte !== got_word.data) begin
          report_mismatch("frame_byte", got_word.data, frame_bus.frame_byte);
        end
        if (frame_bus.frame_end !== got_word.last) begin
          report_mismatch("frame_end", 8'(got_word.last), 8'(frame_bus.frame_end));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycle_cnt  = 0;
    stall_left = 0;
    no_idle    = 1'b0;
    rst_ni     = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = acfb_pkg::RegRollMax;
    cfg_bus.data  = '0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.roll_delta   = '0;
    cmd_bus.roll_time    = '0;
    cmd_bus.pitch_delta  = '0;
    cmd_bus.pitch_time   = '0;
    cmd_bus.yaw_delta    = '0;
    cmd_bus.yaw_time     = '0;
    cmd_bus.thrust_delta = '0;
    cmd_bus.thrust_time  = '0;
    frame_bus.ready = 1'b0;
    for (int a = 0; a < acfb_pkg::NumAxes; a++) begin
      axis_max[a] = acfb_pkg::LimitMaxReset;
      axis_min[a] = acfb_pkg::LimitMinReset;
    end

    // reset limits pass everything through
    script.push_back(cmd_row(64'h00_00_00_00_00_00_00_00, 1'b1, 40'h00_00_00_00_00));
    script.push_back(cmd_row(64'h7f_ff_7f_ff_7f_ff_7f_ff, 1'b1, 40'h7f_7f_7f_7f_f8));
    script.push_back(cmd_row(64'h80_00_80_00_80_00_80_00, 1'b1, 40'h80_80_80_80_00));
    script.push_back(cmd_row(64'h01_01_ff_80_55_aa_aa_55, 1'b0, '0));
    // narrow roll, zero-width pitch, crossed yaw at the extremes, crossed thrust
    script.push_back(cfg_row(acfb_pkg::RegRollMax, 8'h0a));
    script.push_back(cfg_row(acfb_pkg::RegRollMin, 8'hf6));
    script.push_back(cfg_row(acfb_pkg::RegPitchMax, 8'h00));
    script.push_back(cfg_row(acfb_pkg::RegPitchMin, 8'h00));
    script.push_back(cfg_row(acfb_pkg::RegYawMax, 8'h80));
    script.push_back(cfg_row(acfb_pkg::RegYawMin, 8'h7f));
    script.push_back(cfg_row(acfb_pkg::RegThrustMax, 8'hec));
    script.push_back(cfg_row(acfb_pkg::RegThrustMin, 8'h14));
    script.push_back(cmd_row(64'h7f_12_7f_34_7f_56_7f_78, 1'b1, 40'h0a_00_7f_14_b1));
    script.push_back(cmd_row(64'h80_00_80_00_80_00_80_00, 1'b1, 40'hf6_00_7f_14_89));
    script.push_back(cmd_row(64'h05_11_00_22_00_33_00_44, 1'b0, '0));
    script.push_back(cmd_row(64'h0a_ff_01_01_00_00_15_80, 1'b0, '0));
    script.push_back(cmd_row(64'hf6_5a_ff_a5_55_0f_eb_f0, 1'b0, '0));
    script.push_back(cmd_row(64'h0b_c3_f5_3c_81_99_ec_66, 1'b0, '0));
    // pinned roll and pitch at opposite extremes, yaw and thrust wide open again
    script.push_back(cfg_row(acfb_pkg::RegRollMax, 8'h80));
    script.push_back(cfg_row(acfb_pkg::RegRollMin, 8'h80));
    script.push_back(cfg_row(acfb_pkg::RegPitchMax, 8'h7f));
    script.push_back(cfg_row(acfb_pkg::RegPitchMin, 8'h7f));
    script.push_back(cfg_row(acfb_pkg::RegYawMax, 8'h7f));
    script.push_back(cfg_row(acfb_pkg::RegYawMin, 8'h80));
    script.push_back(cfg_row(acfb_pkg::RegThrustMax, 8'h7f));
    script.push_back(cfg_row(acfb_pkg::RegThrustMin, 8'h80));
    script.push_back(cmd_row(64'h7f_ff_80_00_55_aa_aa_55, 1'b1, 40'h80_7f_55_aa_fc));
    script.push_back(cmd_row(64'h00_01_00_02_00_04_00_08, 1'b0, '0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == RowCfg) write_limit(script[i].idx, script[i].data);
      else send_cmd(script[i].cmd, script[i].typed, script[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 3 == 1);
      for (int r = 0; r < 8; r++) begin
        write_limit(acfb_pkg::reg_idx_e'(r), pick_limit());
      end
      for (int n = 0; n < 62; n++) begin
        send_cmd(random_cmd(), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
